/* hdl/aces_srgb_tone_mapper_assert.svh */
// Assertion macros shared by the tone mapper RTL.
`ifndef ACES_SRGB_TONE_MAPPER_ASSERT_SVH
`define ACES_SRGB_TONE_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACES_TM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACES_TM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/aces_tm_pkg.sv */
// Package: widths, stage map, curve constants and gamma tables of the tone mapper.
package aces_tm_pkg;

  localparam int INPUT_FRAC_BITS       = 16;
  localparam int GAMMA_TABLE_ADDR_BITS = 12;

  localparam int IN_W      = 24;
  localparam int CODE_W    = 8;
  localparam int TONE_BITS = 24;
  localparam int ROOT_BITS = 16;

  // curve datapath widths
  localparam int COEF_W = IN_W + 9;
  localparam int ND_W   = IN_W + COEF_W;
  localparam int REM_W  = ND_W + 1;
  localparam int T_W    = TONE_BITS + 1;

  // gamma table addressing
  localparam int FRAC_W = TONE_BITS - GAMMA_TABLE_ADDR_BITS;
  localparam int ADDR_W = GAMMA_TABLE_ADDR_BITS + 1;
  localparam int HALF   = 1 << (GAMMA_TABLE_ADDR_BITS - 1);
  localparam int EV_W   = GAMMA_TABLE_ADDR_BITS;
  localparam int OD_W   = GAMMA_TABLE_ADDR_BITS - 1;
  localparam int P_W    = ROOT_BITS + 1;
  localparam int PROD_W = P_W + FRAC_W;

  // encode datapath widths
  localparam int S_W     = P_W + 11;
  localparam int GAIN_W  = S_W + 15;
  localparam int Z_W     = GAIN_W - ROOT_BITS;
  localparam int PRE_SH  = 5;
  localparam int W_W     = Z_W - PRE_SH;
  localparam int RCP_SH  = 32;
  localparam int RCP_W   = 21;
  localparam int RPROD_W = W_W + RCP_W;
  localparam int Q_W     = RPROD_W - RCP_SH;

  // curve coefficients, scaled by 100
  localparam int COEF_N1 = 251;
  localparam int COEF_N0 = 3;
  localparam int COEF_D1 = 243;
  localparam int COEF_D0 = 59;
  localparam int COEF_DC = 14;

  // display encode constants
  localparam int GAMMA_MUL = 1055;
  localparam int GAMMA_OFF = 55 << ROOT_BITS;
  localparam int ENC_MUL   = 25599;
  localparam longint unsigned RCP_MUL =
    ((64'd1 << RCP_SH) + 64'd3124) / 64'd3125;

  // linear segment: tone below LIN_LIMIT, code from threshold count
  localparam longint unsigned LIN_LIMIT =
    ((64'd31308 << TONE_BITS) + 64'd9999999) / 64'd10000000;
  localparam longint unsigned LIN_MUL = 64'd1292 * 64'd25599;
  localparam longint unsigned LIN_DEN = 64'd10000 << TONE_BITS;
  localparam int LIN_STEPS  = 10;
  localparam int LIN_CODE_W = 4;
  localparam longint unsigned LinThr [LIN_STEPS] = '{
    (64'd1  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd2  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd3  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd4  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd5  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd6  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd7  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd8  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd9  * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL,
    (64'd10 * LIN_DEN + LIN_MUL - 64'd1) / LIN_MUL
  };

  // pipeline stage map
  localparam int ST_COEF   = 0;
  localparam int ST_PROD   = 1;
  localparam int ST_DIV0   = 2;
  localparam int ST_ROM    = ST_DIV0 + TONE_BITS;
  localparam int ST_INTERP = ST_ROM + 1;
  localparam int ST_SCALE  = ST_INTERP + 1;
  localparam int ST_GAIN   = ST_SCALE + 1;
  localparam int ST_RECIP  = ST_GAIN + 1;
  localparam int ST_OUT    = ST_RECIP + 1;
  localparam int NSTG      = ST_OUT + 1;

  typedef logic [NSTG-1:0] stage_en_t;
  typedef logic [P_W-1:0]  root_t;
  typedef root_t rom_even_t [HALF+1];
  typedef root_t rom_odd_t  [HALF];

  // floor((a / 2^G)^(5/11) * 2^16), exact by integer search
  function automatic root_t rom_entry(input int unsigned a);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs = 192'd1;
    for (int i = 0; i < 5; i++) rhs = rhs * 192'(a);
    rhs = rhs << (176 - 5 * GAMMA_TABLE_ADDR_BITS);
    lo = 0;
    hi = 1 << ROOT_BITS;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 192'd1;
      for (int j = 0; j < 11; j++) lhs = lhs * 192'(mid);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return root_t'(lo);
  endfunction

  function automatic rom_even_t build_even();
    rom_even_t r;
    for (int i = 0; i <= HALF; i++) r[i] = rom_entry(2 * i);
    return r;
  endfunction

  function automatic rom_odd_t build_odd();
    rom_odd_t r;
    for (int i = 0; i < HALF; i++) r[i] = rom_entry(2 * i + 1);
    return r;
  endfunction

  localparam rom_even_t GAMMA_EVEN = build_even();
  localparam rom_odd_t  GAMMA_ODD  = build_odd();

endpackage

/* hdl/aces_tm_pix_if.sv */
// Interface: pixel input channel, three linear channels with valid/ready.
interface aces_tm_pix_if import aces_tm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] red_linear;
  logic [IN_W-1:0] green_linear;
  logic [IN_W-1:0] blue_linear;

  modport source (output valid, output red_linear, output green_linear,
                  output blue_linear, input ready);
  modport sink   (input valid, input red_linear, input green_linear,
                  input blue_linear, output ready);
endinterface

/* hdl/aces_tm_code_if.sv */
// Interface: display code output channel with valid/ready.
interface aces_tm_code_if import aces_tm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] green_code;
  logic [CODE_W-1:0] blue_code;

  modport source (output valid, output red_code, output green_code,
                  output blue_code, input ready);
  modport sink   (input valid, input red_code, input green_code,
                  input blue_code, output ready);
endinterface

/* hdl/aces_tm_chan.sv */
// Module: one color channel datapath, filmic curve, divider, gamma encode.
module aces_tm_chan import aces_tm_pkg::*; (
  input  logic              clk,
  input  stage_en_t         en,
  input  logic [IN_W-1:0]   lin_in,
  output logic [CODE_W-1:0] code_out
);

  // coefficient stage
  logic [IN_W-1:0]   v_r;
  logic [COEF_W-1:0] an_r, ad_r;
  logic [COEF_W-1:0] an_nxt, ad_nxt;

  assign an_nxt = COEF_W'(lin_in) * COEF_W'(COEF_N1)
                + (COEF_W'(COEF_N0) << INPUT_FRAC_BITS);
  assign ad_nxt = COEF_W'(lin_in) * COEF_W'(COEF_D1)
                + (COEF_W'(COEF_D0) << INPUT_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[ST_COEF]) begin
      v_r  <= lin_in;
      an_r <= an_nxt;
      ad_r <= ad_nxt;
    end
  end

  // numerator and denominator products
  logic [ND_W-1:0] num_r, den_r;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      num_r <= ND_W'(v_r) * ND_W'(an_r);
      den_r <= ND_W'(v_r) * ND_W'(ad_r) + (ND_W'(COEF_DC) << (2 * INPUT_FRAC_BITS));
    end
  end

  // restoring divider, one quotient bit per stage
  logic [ND_W-1:0]      rem_r [TONE_BITS-1];
  logic [ND_W-1:0]      dq_r  [TONE_BITS-1];
  logic [TONE_BITS-1:0] quo_r [TONE_BITS];
  logic                 sat_r [TONE_BITS];

  for (genvar k = 0; k < TONE_BITS; k++) begin : g_div
    logic [ND_W-1:0]      rem_in, den_in;
    logic [TONE_BITS-1:0] quo_in;
    logic                 sat_in;
    logic [REM_W-1:0]     shl;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = num_r;
      assign den_in = den_r;
      assign quo_in = '0;
      assign sat_in = (num_r >= den_r);
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = dq_r[k-1];
      assign quo_in = quo_r[k-1];
      assign sat_in = sat_r[k-1];
    end

    assign shl = {rem_in, 1'b0};
    assign ge  = (shl >= REM_W'(den_in));

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + k]) begin
        quo_r[k] <= {quo_in[TONE_BITS-2:0], ge};
        sat_r[k] <= sat_in;
      end
    end

    // the last step needs only its quotient bit
    if (k < TONE_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[ST_DIV0 + k]) begin
          rem_r[k] <= ge ? ND_W'(shl - REM_W'(den_in)) : ND_W'(shl);
          dq_r[k]  <= den_in;
        end
      end
    end
  end

  // tone value in Q0.24, saturated curve gives exactly one
  logic [T_W-1:0] tone;
  assign tone = sat_r[TONE_BITS-1] ? (T_W'(1) << TONE_BITS)
                                   : {1'b0, quo_r[TONE_BITS-1]};

  // linear segment code and table addressing
  logic [LIN_CODE_W-1:0] lcode;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W-1:0]     ev_sum;

  always_comb begin
    lcode = '0;
    for (int i = 0; i < LIN_STEPS; i++) begin
      lcode = lcode + LIN_CODE_W'(tone >= T_W'(LinThr[i]));
    end
  end

  assign addr   = tone[T_W-1:FRAC_W];
  assign ev_sum = addr + ADDR_W'(1);

  logic [P_W-1:0]        ev_r, od_r;
  logic                  odd_r, top_r, lin_r;
  logic [FRAC_W-1:0]     f_r;
  logic [LIN_CODE_W-1:0] lcode_r;

  always_ff @(posedge clk) begin
    if (en[ST_ROM]) begin
      ev_r    <= GAMMA_EVEN[ev_sum[ADDR_W-1:1]];
      od_r    <= GAMMA_ODD[addr[ADDR_W-2:1]];
      odd_r   <= addr[0];
      top_r   <= addr[ADDR_W-1];
      f_r     <= tone[FRAC_W-1:0];
      lin_r   <= (tone < T_W'(LIN_LIMIT));
      lcode_r <= lcode;
    end
  end

  // interpolation product
  logic [P_W-1:0]        e0, e1;
  logic [P_W-1:0]        e0_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  top2_r, lin2_r;
  logic [LIN_CODE_W-1:0] lcode2_r;

  assign e0 = odd_r ? od_r : ev_r;
  assign e1 = odd_r ? ev_r : od_r;

  always_ff @(posedge clk) begin
    if (en[ST_INTERP]) begin
      e0_r     <= e0;
      prod_r   <= PROD_W'(e1 - e0) * PROD_W'(f_r);
      top2_r   <= top_r;
      lin2_r   <= lin_r;
      lcode2_r <= lcode_r;
    end
  end

  // power value and gain
  logic [P_W-1:0]        pw;
  logic [S_W-1:0]        s_r;
  logic                  lin3_r;
  logic [LIN_CODE_W-1:0] lcode3_r;

  assign pw = top2_r ? (P_W'(1) << ROOT_BITS)
                     : e0_r + P_W'(prod_r >> FRAC_W);

  always_ff @(posedge clk) begin
    if (en[ST_SCALE]) begin
      s_r      <= S_W'(pw) * S_W'(GAMMA_MUL);
      lin3_r   <= lin2_r;
      lcode3_r <= lcode2_r;
    end
  end

  // remove offset, scale by 255.99 and drop the low fraction
  logic [S_W-1:0]        y;
  logic [GAIN_W-1:0]     gain;
  logic [Z_W-1:0]        z_r;
  logic                  lin4_r;
  logic [LIN_CODE_W-1:0] lcode4_r;

  assign y    = (s_r > S_W'(GAMMA_OFF)) ? s_r - S_W'(GAMMA_OFF) : '0;
  assign gain = GAIN_W'(y) * GAIN_W'(ENC_MUL);

  always_ff @(posedge clk) begin
    if (en[ST_GAIN]) begin
      z_r      <= gain[GAIN_W-1:ROOT_BITS];
      lin4_r   <= lin3_r;
      lcode4_r <= lcode3_r;
    end
  end

  // divide by 100000: drop 2^5, then reciprocal multiply for 3125
  logic [W_W-1:0]        w;
  logic [RPROD_W-1:0]    rprod;
  logic [Q_W-1:0]        q_r;
  logic                  lin5_r;
  logic [LIN_CODE_W-1:0] lcode5_r;

  assign w     = z_r[Z_W-1:PRE_SH];
  assign rprod = RPROD_W'(w) * RPROD_W'(RCP_MUL);

  always_ff @(posedge clk) begin
    if (en[ST_RECIP]) begin
      q_r      <= rprod[RPROD_W-1:RCP_SH];
      lin5_r   <= lin4_r;
      lcode5_r <= lcode4_r;
    end
  end

  // select segment and clamp
  logic [CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (lin5_r) begin
        code_r <= CODE_W'(lcode5_r);
      end else if (q_r > Q_W'(255)) begin
        code_r <= '1;
      end else begin
        code_r <= q_r[CODE_W-1:0];
      end
    end
  end

  assign code_out = code_r;

endmodule

/* hdl/aces_srgb_tone_mapper.sv */
// Top level: three-channel filmic tone mapper with display gamma encode.
//
// Usage:
//   in_ch carries one linear HDR pixel per transaction: red_linear,
//   green_linear and blue_linear, unsigned Q8.16. out_ch carries the
//   matching 8-bit display codes red_code, green_code and blue_code.
//   A transaction moves on a rising clk edge with valid and ready high.
//   Every pixel yields exactly one result, in order.
// Pipeline and throughput:
//   Two stages form the curve numerator and denominator, 24 stages run
//   the restoring divider (one quotient bit each), six stages do gamma
//   table lookup, interpolation and the final scaling. One pixel per cycle
//   sustained while out_ch.ready stays high.
// Reset:
//   rst_n low (synchronous) empties the pipeline; payload registers are not reset.
// Stall:
//   While out_ch.ready is low the output holds. Bubbles inside the pipeline
//   still close up, so in_ch.ready drops only when all stages are full.
`include "aces_srgb_tone_mapper_assert.svh"

module aces_srgb_tone_mapper import aces_tm_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  aces_tm_pix_if.sink    in_ch,
  aces_tm_code_if.source out_ch
);

  logic [NSTG-1:0] valid_r, valid_nxt, valid_src;
  stage_en_t       en;

  // a stage loads when it is empty or when its successor advances
  assign en[NSTG-1] = !valid_r[NSTG-1] || out_ch.ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en[i] = !valid_r[i] || en[i+1];
  end

  assign valid_src = {valid_r[NSTG-2:0], in_ch.valid};

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      valid_nxt[i] = en[i] ? valid_src[i] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = valid_r[NSTG-1];

  // identical datapaths, one per color
  aces_tm_chan u_red (
    .clk      (clk),
    .en       (en),
    .lin_in   (in_ch.red_linear),
    .code_out (out_ch.red_code)
  );

  aces_tm_chan u_green (
    .clk      (clk),
    .en       (en),
    .lin_in   (in_ch.green_linear),
    .code_out (out_ch.green_code)
  );

  aces_tm_chan u_blue (
    .clk      (clk),
    .en       (en),
    .lin_in   (in_ch.blue_linear),
    .code_out (out_ch.blue_code)
  );

  // checks
  `ACES_TM_ASSERT_NOW(a_ready_when_out_empty, !out_ch.valid, in_ch.ready, "input blocked with empty output")
  `ACES_TM_ASSERT_NOW(a_block_only_when_full, !in_ch.ready, &valid_r, "input blocked with a bubble in flight")
  `ACES_TM_ASSERT_NEXT(a_no_phantom_output, (valid_r == '0) && !in_ch.valid, !out_ch.valid, "output from empty pipeline")

endmodule
